FILE: design/skrf_pkg.sv
// shared types and constants for the scalar kalman rssi filter
package skrf_pkg;

  localparam int CFG_W     = 32;
  localparam int IDX_W     = 2;
  localparam int MEAS_W    = 16;
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  localparam logic [CFG_W-1:0] MEASURE_NOISE_RESET = 32'd65536;
  localparam logic [CFG_W-1:0] INITIAL_ERROR_RESET = 32'd65536;
  localparam logic [CFG_W-1:0] PROCESS_NOISE_RESET = 32'd655;

  typedef enum logic [IDX_W-1:0] {
    REG_MEASURE_NOISE = 2'd0,
    REG_INITIAL_ERROR = 2'd1,
    REG_PROCESS_NOISE = 2'd2
  } cfg_reg_t;

endpackage

FILE: design/skrf_ser_mul.sv
// shift-add serial multiplier, one multiplier bit per cycle
module skrf_ser_mul #(
  parameter int MCAND_W = 17,
  parameter int MPLR_W  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [MCAND_W-1:0]        mcand,
  input  logic [MPLR_W-1:0]         mplr,
  output logic [MCAND_W+MPLR_W-1:0] product,
  output logic                      done
);

  localparam int CW = $clog2(MPLR_W + 1);

  logic [MCAND_W-1:0]        mcand_q;
  logic [MCAND_W+MPLR_W-1:0] prod;
  logic [CW-1:0]             count;
  logic                      busy;
  logic [MCAND_W:0]          sum;

  always_comb begin
    sum = {1'b0, prod[MPLR_W +: MCAND_W]} + (prod[0] ? {1'b0, mcand_q} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand_q <= mcand;
        prod    <= {{MCAND_W{1'b0}}, mplr};
        count   <= CW'(MPLR_W);
        busy    <= 1'b1;
      end else if (busy) begin
        prod  <= {sum, prod[MPLR_W-1:1]};
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = prod;

endmodule

FILE: design/skrf_gain_div.sv
// restoring divider for the gain, one quotient bit per cycle
module skrf_gain_div #(
  parameter int DEN_W = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DEN_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  output logic [skrf_pkg::GAIN_W-1:0] quot,
  output logic                       done
);

  import skrf_pkg::*;

  localparam int CW = $clog2(GAIN_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [GAIN_W-1:0] quot_q;
  logic [CW-1:0]     count;
  logic              busy;
  logic              den_zero;
  logic [DEN_W:0]    rem_sh;
  logic              ge;
  logic [DEN_W:0]    rem_sub;

  always_comb begin
    rem_sh  = (count == CW'(GAIN_W)) ? {1'b0, rem} : {rem, 1'b0};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      count    <= '0;
      den_zero <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= num;
        den_q    <= den;
        quot_q   <= '0;
        den_zero <= (den == '0);
        count    <= CW'(GAIN_W);
        busy     <= 1'b1;
      end else if (busy) begin
        rem    <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quot_q <= {quot_q[GAIN_W-2:0], ge};
        count  <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // zero denominator gives zero gain
  assign quot = den_zero ? '0 : quot_q;

endmodule

FILE: design/scalar_kalman_rssi_filter_unit.sv
// top level of the scalar kalman rssi filter
// an accepted word runs through the serial gain divider, then the step and keep
// multipliers side by side, then the process-noise multiplier, and then the output
// register; a new word is taken only once the previous estimate has been loaded there
// a finished estimate waits in the output register while the next word is taken
// reset: synchronous, restores register defaults, loads variance, clears the stored estimate
module scalar_kalman_rssi_filter_unit #(
  parameter int EST_FRAC_BITS = 8,
  parameter int VAR_WIDTH     = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [skrf_pkg::MEAS_W-1:0] measurement,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [skrf_pkg::MEAS_W-1:0] estimate,
  input  logic                              cfg_we,
  input  logic [skrf_pkg::IDX_W-1:0]        cfg_index,
  input  logic [skrf_pkg::CFG_W-1:0]        cfg_data
);

  import skrf_pkg::*;

  localparam int IW      = (VAR_WIDTH > CFG_W) ? VAR_WIDTH : CFG_W;
  localparam int DEN_W   = IW + 1;
  localparam int STEP_PW = GAIN_W + MEAS_W;
  localparam int KEEP_PW = VAR_WIDTH + GAIN_W;
  localparam int ADD_PW  = CFG_W + MEAS_W;
  localparam int SUM_W   = ((VAR_WIDTH > ADD_PW) ? VAR_WIDTH : ADD_PW) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                    state;
  logic [CFG_W-1:0]          measure_noise;
  logic [CFG_W-1:0]          process_noise;
  logic [VAR_WIDTH-1:0]      error_variance;
  logic signed [MEAS_W-1:0]  last_value;
  logic [MEAS_W-1:0]         dmag;
  logic                      dneg;

  logic signed [MEAS_W:0]    diff;
  logic [MEAS_W:0]           diff_neg;
  logic [MEAS_W-1:0]         dmag_c;
  logic                      accept;
  logic [DEN_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic [GAIN_W-1:0]         gain;
  logic                      div_done;
  logic                      mul_start;
  logic                      add_start;
  logic [GAIN_W-1:0]         keep_factor;
  logic [STEP_PW-1:0]        step_prod;
  logic                      step_done;
  logic [KEEP_PW-1:0]        keep_prod;
  logic                      keep_done;
  logic [ADD_PW-1:0]         add_prod;
  logic                      add_done;
  logic [MEAS_W-1:0]         moved;
  logic signed [MEAS_W:0]    step_s;
  logic signed [MEAS_W:0]    est_wide;
  logic [ADD_PW-1:0]         add_shift;
  logic [SUM_W-1:0]          var_sum;
  logic [VAR_WIDTH-1:0]      var_sat;

  function automatic logic [VAR_WIDTH-1:0] sat_load(input logic [CFG_W-1:0] v);
    logic [IW:0] ext;
    ext = {1'b0, IW'(v)};
    if ((ext >> VAR_WIDTH) != '0) begin
      sat_load = '1;
    end else begin
      sat_load = ext[VAR_WIDTH-1:0];
    end
  endfunction

  always_comb begin
    accept    = in_valid && in_ready;
    diff      = {measurement[MEAS_W-1], measurement} - {last_value[MEAS_W-1], last_value};
    diff_neg  = -diff;
    dmag_c    = diff[MEAS_W] ? diff_neg[MEAS_W-1:0] : diff[MEAS_W-1:0];
    div_num   = DEN_W'(error_variance);
    div_den   = DEN_W'(error_variance) + DEN_W'(measure_noise);
    mul_start = (state == S_DIV) && div_done;
    add_start = (state == S_MUL) && keep_done;
    keep_factor = GAIN_ONE - gain;
    moved     = step_prod[GAIN_FRAC +: MEAS_W];
    step_s    = dneg ? -$signed({1'b0, moved}) : $signed({1'b0, moved});
    est_wide  = {last_value[MEAS_W-1], last_value} + step_s;
    add_shift = add_prod >> EST_FRAC_BITS;
    var_sum   = SUM_W'(keep_prod[GAIN_FRAC +: VAR_WIDTH]) + SUM_W'(add_shift);
    var_sat   = ((var_sum >> VAR_WIDTH) != '0) ? '1 : var_sum[VAR_WIDTH-1:0];
  end

  assign in_ready = (state == S_IDLE);

  skrf_gain_div #(
    .DEN_W(DEN_W)
  ) u_gain_div (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .num  (div_num),
    .den  (div_den),
    .quot (gain),
    .done (div_done)
  );

  skrf_ser_mul #(
    .MCAND_W(GAIN_W),
    .MPLR_W (MEAS_W)
  ) u_step_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (gain),
    .mplr   (dmag),
    .product(step_prod),
    .done   (step_done)
  );

  skrf_ser_mul #(
    .MCAND_W(VAR_WIDTH),
    .MPLR_W (GAIN_W)
  ) u_keep_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (error_variance),
    .mplr   (keep_factor),
    .product(keep_prod),
    .done   (keep_done)
  );

  skrf_ser_mul #(
    .MCAND_W(CFG_W),
    .MPLR_W (MEAS_W)
  ) u_add_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (add_start),
    .mcand  (process_noise),
    .mplr   (moved),
    .product(add_prod),
    .done   (add_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      measure_noise  <= MEASURE_NOISE_RESET;
      process_noise  <= PROCESS_NOISE_RESET;
      error_variance <= sat_load(INITIAL_ERROR_RESET);
      last_value     <= '0;
      dneg           <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dmag  <= dmag_c;
            dneg  <= diff[MEAS_W];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // step product is ready before the keep product
          if (keep_done) begin
            last_value <= est_wide[MEAS_W-1:0];
            state      <= S_ADD;
          end
        end
        S_ADD: begin
          if (add_done) begin
            error_variance <= var_sat;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            estimate  <= last_value;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MEASURE_NOISE: measure_noise <= cfg_data;
          REG_INITIAL_ERROR: begin
            error_variance <= sat_load(cfg_data);
            last_value     <= '0;
          end
          REG_PROCESS_NOISE: process_noise <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  logic unused_step_done;
  assign unused_step_done = step_done;

endmodule

FILE: design/skrf_checker.sv
// port-level checks for the scalar kalman rssi filter, bound to the top level
module skrf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [skrf_pkg::MEAS_W-1:0] estimate
);

  import skrf_pkg::*;

  // reset leaves the block empty and ready
  assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  // one word at a time
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while busy");

  // no result appears in the cycle after a word is taken
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("estimate appeared too early");

  // a stalled estimate holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(estimate)))
    else $error("stalled estimate changed");

endmodule

bind scalar_kalman_rssi_filter_unit skrf_checker u_skrf_checker (.*);

FILE: tb/scalar_kalman_rssi_filter_unit_tb.sv
// self-checking testbench for the scalar kalman rssi filter unit
`timescale 1ns / 1ps

module scalar_kalman_rssi_filter_unit_tb;
  import skrf_pkg::*;

  localparam int EST_FRAC = 8;
  localparam int VAR_W    = 32;
  localparam longint unsigned VAR_MAX = (64'd1 << VAR_W) - 1;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [CFG_W-1:0] CFG_MAX   = '1;
  localparam int RANDOM_WORDS = 850;
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [MEAS_W-1:0] measurement = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [MEAS_W-1:0] estimate;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // filter state and register copies
  logic [CFG_W-1:0] noise_meas_cfg;
  logic [CFG_W-1:0] init_err_cfg;
  logic [CFG_W-1:0] noise_proc_cfg;
  logic signed [MEAS_W-1:0] est_model;
  longint unsigned var_model;

  logic signed [MEAS_W-1:0] pending_words[$];
  logic signed [MEAS_W-1:0] est_due[$];

  int words_queued = 0;
  int words_in = 0;
  int estimates_checked = 0;
  int reg_writes = 0;
  int settings = 0;
  int directed_words = 0;
  int mismatches = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit quiet = 1'b0;

  scalar_kalman_rssi_filter_unit #(
    .EST_FRAC_BITS(EST_FRAC),
    .VAR_WIDTH(VAR_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .measurement(measurement),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .estimate(estimate),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d estimates still due", est_due.size());
    $display("scalar_kalman_rssi_filter_unit_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic filter_step(input logic signed [MEAS_W-1:0] meas,
                             output logic signed [MEAS_W-1:0] est);
    longint unsigned p;
    longint unsigned denom;
    longint unsigned gain;
    longint unsigned keep;
    longint unsigned add;
    longint unsigned moved;
    longint unsigned next_var;
    longint diff;
    longint step;
    p = var_model;
    denom = p + noise_meas_cfg;
    gain = 0;
    if (denom != 0) gain = (p << GAIN_FRAC) / denom;
    if (gain > GAIN_ONE) gain = GAIN_ONE;
    diff = longint'(meas) - longint'(est_model);
    // signed division truncates toward zero
    step = (longint'(gain) * diff) / (longint'(1) << GAIN_FRAC);
    moved = (step < 0) ? longint'(-step) : longint'(step);
    keep = ((longint'(GAIN_ONE) - gain) * p) >> GAIN_FRAC;
    add = (moved * noise_proc_cfg) >> EST_FRAC;
    next_var = keep + add;
    if (next_var > VAR_MAX) next_var = VAR_MAX;
    var_model = next_var;
    est_model = MEAS_W'(longint'(est_model) + step);
    est = est_model;
  endtask

  task automatic load_initial_error();
    var_model = (longint'(init_err_cfg) > VAR_MAX) ? VAR_MAX : longint'(init_err_cfg);
    est_model = '0;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MEASURE_NOISE: noise_meas_cfg = data;
      REG_INITIAL_ERROR: begin
        init_err_cfg = data;
        load_initial_error();
      end
      REG_PROCESS_NOISE: noise_proc_cfg = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic queue_word(input logic signed [MEAS_W-1:0] m);
    pending_words.push_back(m);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_in != words_queued || est_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    settings++;
  endtask

  function automatic logic [CFG_W-1:0] pick_cfg();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CFG_MAX;
      2: return $urandom;
      3: return $urandom_range(0, 1 << 20);
      default: return $urandom_range(1 << 12, 1 << 18);
    endcase
  endfunction

  // mostly noisy samples around a signal level, with jumps, noise and extremes
  function automatic logic signed [MEAS_W-1:0] pick_sample(input int level);
    int v;
    case ($urandom_range(0, 9))
      6, 7: return MEAS_W'($urandom);
      8: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      9: v = -int'($urandom_range(1280, 32768));
      default: v = level + int'($urandom_range(0, 2047)) - 1024;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return MEAS_W'(v);
  endfunction

  always @(posedge clk) begin : drive
    logic next_valid;
    logic signed [MEAS_W-1:0] next_meas;
    logic signed [MEAS_W-1:0] est;
    if (rst) begin
      in_valid <= 1'b0;
      measurement <= '0;
      in_gap = 0;
    end else begin
      next_valid = in_valid;
      next_meas = measurement;
      if (in_valid && in_ready) begin
        filter_step(measurement, est);
        est_due.push_back(est);
        words_in++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(0, 6);
          end else begin
            next_meas = pending_words.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
      measurement <= next_meas;
    end
  end

  always @(posedge clk) begin : watch
    logic signed [MEAS_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (est_due.size() == 0) begin
          report_mismatch($sformatf("estimate %0d with none due", estimate));
        end else begin
          want = est_due.pop_front();
          estimates_checked++;
          if (estimate !== want)
            report_mismatch($sformatf("estimate %0d, expected %0d", estimate, want));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int random_words;
    int n;
    int level;
    int k;
    noise_meas_cfg = MEASURE_NOISE_RESET;
    init_err_cfg = INITIAL_ERROR_RESET;
    noise_proc_cfg = PROCESS_NOISE_RESET;
    load_initial_error();
    random_words = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings, field extremes and alternating bits
    queue_word(16'sh0000);
    queue_word(16'sh7fff);
    queue_word(16'sh8000);
    queue_word(16'sh7fff);
    queue_word(16'sh0001);
    queue_word(-16'sh0001);
    queue_word(16'sh5555);
    queue_word(16'shaaaa);
    queue_word(16'sh0100);
    queue_word(-16'sh3c00);
    wait_drained();

    // no measurement noise: estimate follows the sample
    write_reg(REG_MEASURE_NOISE, '0);
    queue_word(16'sh7fff);
    queue_word(16'sh8000);
    queue_word(16'sh0064);
    wait_drained();

    // spare index is ignored, then zero variance with zero noise
    write_reg(REG_SPARE, CFG_MAX);
    write_reg(REG_INITIAL_ERROR, '0);
    queue_word(16'sh01f4);
    queue_word(-16'sh01f4);
    wait_drained();

    // everything at its maximum, variance saturates
    write_reg(REG_MEASURE_NOISE, CFG_MAX);
    write_reg(REG_PROCESS_NOISE, CFG_MAX);
    write_reg(REG_INITIAL_ERROR, CFG_MAX);
    queue_word(16'sh7fff);
    queue_word(16'sh8000);
    queue_word(16'sh7fff);
    queue_word(16'sh0000);
    wait_drained();

    // no process noise, tiny starting variance
    write_reg(REG_PROCESS_NOISE, '0);
    write_reg(REG_MEASURE_NOISE, MEASURE_NOISE_RESET);
    write_reg(REG_INITIAL_ERROR, 32'd1);
    queue_word(16'sh8000);
    queue_word(16'sh7fff);
    wait_drained();
    directed_words = words_queued;

    while (random_words < RANDOM_WORDS) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) write_reg(IDX_W'($urandom_range(0, 3)), pick_cfg());
      if (RANDOM_WORDS - random_words <= 80) begin
        // settle on a typical setting with no idling to finish
        quiet = 1'b1;
        write_reg(REG_MEASURE_NOISE, 32'd65536);
        write_reg(REG_PROCESS_NOISE, PROCESS_NOISE_RESET);
        write_reg(REG_INITIAL_ERROR, 32'd65536);
        n = RANDOM_WORDS - random_words;
      end else begin
        n = $urandom_range(20, 90);
      end
      level = -int'($urandom_range(5120, 30720));
      for (k = 0; k < n; k++) queue_word(pick_sample(level));
      random_words += n;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d words (%0d directed) over %0d settings and %0d register writes",
             words_queued, directed_words, settings, reg_writes);
    $display("%0d estimates checked, %0d mismatches", estimates_checked, mismatches);
    if (mismatches == 0 && est_due.size() == 0) begin
      $display("scalar_kalman_rssi_filter_unit_tb OK");
    end else begin
      $display("scalar_kalman_rssi_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/skrf_pkg.sv
design/skrf_ser_mul.sv
design/skrf_gain_div.sv
design/scalar_kalman_rssi_filter_unit.sv
design/skrf_checker.sv
tb/scalar_kalman_rssi_filter_unit_tb.sv
